FILE: design/mpcl_pkg.sv
// shared types, constants and codes of the mesh point cell locator
package mpcl_pkg;

    localparam int MAX_CELLS_DEF    = 4096;
    localparam int MAX_VERTICES_DEF = 8192;
    localparam int COORD_BITS_DEF   = 32;
    localparam int COORD_STRIDE     = 3;

    localparam int REQ_W        = 2;
    localparam int CELL_IDX_W   = 12;
    localparam int CORNER_W     = 3;
    localparam int VERTEX_W     = 13;
    localparam int AXIS_W       = 2;
    localparam int COORD_W      = 32;
    localparam int CELL_COUNT_W = 13;
    localparam int DIMS_W       = 2;

    localparam int CORNERS_2D = 4;
    localparam int CORNERS_3D = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [REQ_W-1:0] REQ_CORNER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COORD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 2'd1;

    localparam logic [DIMS_W-1:0] DIMS_2D    = 2'd2;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [CELL_IDX_W-1:0]   cell_index;
        logic [CORNER_W-1:0]     corner;
        logic [VERTEX_W-1:0]     vertex_index;
        logic [AXIS_W-1:0]       axis;
        logic signed [COORD_W-1:0] coord_value;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic                  found;
        logic [CELL_IDX_W-1:0] cell_id;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_CORNER,
        OP_COORD,
        OP_LOCATE
    } t_op;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_cmd;

    typedef struct packed {
        logic [DIMS_W-1:0]       dims;
        logic [CELL_COUNT_W-1:0] cell_count;
    } t_cfg;

endpackage

FILE: design/mpcl_front.sv
// front end: accepts items, classifies them and drops those that change nothing
module mpcl_front import mpcl_pkg::*; #(
    parameter int MAX_CELLS    = MAX_CELLS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_item,
    output logic     full,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic keep;
    t_op  op;
    logic r_busy_seen;

    always_comb begin
        keep = 1'b0;
        op   = OP_LOCATE;
        unique case (i_item.req_type)
            REQ_CORNER: begin
                op   = OP_CORNER;
                keep = 32'(i_item.cell_index) < 32'(MAX_CELLS);
            end
            REQ_COORD: begin
                op   = OP_COORD;
                keep = (32'(i_item.vertex_index) < 32'(MAX_VERTICES))
                    && (i_item.axis <= AXIS_Z);
            end
            REQ_LOCATE: begin
                op   = OP_LOCATE;
                keep = 1'b1;
            end
            default: begin
                op   = OP_LOCATE;
                keep = 1'b0;
            end
        endcase
    end

    // full is held after reset until r_busy_seen is registered, while the queue pointers settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_seen <= 1'b0;
        end else begin
            r_busy_seen <= 1'b1;
        end
    end

    assign full        = i_q_full || !r_busy_seen;
    assign o_q_push    = push && !full && keep;
    assign o_q_cmd.op  = op;
    assign o_q_cmd.item = i_item;

endmodule

FILE: design/mpcl_cmd_queue.sv
// short command queue between the front end and the scan engine
module mpcl_cmd_queue import mpcl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: design/mpcl_back.sv
// scan engine: mesh tables, pipelined box scan and result register
module mpcl_back import mpcl_pkg::*; #(
    parameter int MAX_CELLS    = MAX_CELLS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_result
);

    localparam int CW  = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int CLW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CAW = CLW + CORNER_W;
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int CAP = (MAX_CELLS < 8191) ? MAX_CELLS : 8191;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                    first;
        logic                    last;
        logic [CELL_COUNT_W-1:0] cell_no;
    } t_tag;

    // mesh tables
    logic [VERTEX_W-1:0] r_corner_mem [MAX_CELLS*CORNERS_3D];
    logic [CW-1:0]       r_mem_x [MAX_VERTICES];
    logic [CW-1:0]       r_mem_y [MAX_VERTICES];
    logic [CW-1:0]       r_mem_z [MAX_VERTICES];
    logic [VERTEX_W-1:0] r_cdata;
    logic [CW-1:0]       r_bx, r_by, r_bz;

    // control
    t_state                  r_state, n_state;
    logic                    r_issue, n_issue;
    logic [CELL_COUNT_W-1:0] r_icell, n_icell;
    logic [CORNER_W-1:0]     r_ik, n_ik;
    logic [CELL_COUNT_W-1:0] r_limit, n_limit;
    logic                    r_flat, n_flat;
    logic                    r_s1_v, n_s1_v;
    logic                    r_s2_v, n_s2_v;
    logic                    r_box_v, n_box_v;
    logic                    r_out_v, n_out_v;
    t_out_item               r_out, n_out;
    t_out_item               r_pend, n_pend;

    // payload
    t_tag                    r_s1_tag, r_s2_tag;
    logic                    r_s2_oob;
    logic [CELL_COUNT_W-1:0] r_box_cell;
    logic signed [CW-1:0]    r_px, r_py, r_pz;
    logic signed [CW-1:0]    r_lo_x, r_lo_y, r_lo_z;
    logic signed [CW-1:0]    r_hi_x, r_hi_y, r_hi_z;

    logic                    cmd_take;
    logic                    corner_we;
    logic                    coord_we;
    logic [CAW-1:0]          corner_waddr;
    logic [CAW-1:0]          corner_raddr;
    logic [VAW-1:0]          coord_waddr;
    logic [VAW-1:0]          coord_raddr;
    logic [CW-1:0]           coord_wdata;
    logic [CORNER_W-1:0]     last_k;
    logic [CELL_COUNT_W-1:0] clamp_count;
    t_tag                    issue_tag;
    logic signed [CW-1:0]    vx, vy, vz;
    logic                    in_x, in_y, in_z, box_hit;

    assign cmd_take  = (r_state == ST_IDLE) && !i_q_empty;
    assign o_q_pop   = cmd_take;
    assign corner_we = cmd_take && (i_q_cmd.op == OP_CORNER);
    assign coord_we  = cmd_take && (i_q_cmd.op == OP_COORD);

    assign corner_waddr = {CLW'(i_q_cmd.item.cell_index), i_q_cmd.item.corner};
    assign corner_raddr = {CLW'(r_icell), r_ik};
    assign coord_waddr  = VAW'(i_q_cmd.item.vertex_index);
    assign coord_raddr  = VAW'(r_cdata);
    assign coord_wdata  = i_q_cmd.item.coord_value[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (corner_we) begin
            r_corner_mem[corner_waddr] <= i_q_cmd.item.vertex_index;
        end
        r_cdata <= r_corner_mem[corner_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (coord_we && (i_q_cmd.item.axis == AXIS_X)) begin
            r_mem_x[coord_waddr] <= coord_wdata;
        end
        if (coord_we && (i_q_cmd.item.axis == AXIS_Y)) begin
            r_mem_y[coord_waddr] <= coord_wdata;
        end
        if (coord_we && (i_q_cmd.item.axis == AXIS_Z)) begin
            r_mem_z[coord_waddr] <= coord_wdata;
        end
        r_bx <= r_mem_x[coord_raddr];
        r_by <= r_mem_y[coord_raddr];
        r_bz <= r_mem_z[coord_raddr];
    end

    assign last_k      = r_flat ? CORNER_W'(CORNERS_2D - 1) : CORNER_W'(CORNERS_3D - 1);
    assign clamp_count = (32'(i_cfg.cell_count) > 32'(CAP)) ? CELL_COUNT_W'(CAP)
                                                             : i_cfg.cell_count;

    assign issue_tag.first   = r_ik == '0;
    assign issue_tag.last    = r_ik == last_k;
    assign issue_tag.cell_no = r_icell;

    // vertex beyond the table reads as the origin
    assign vx = r_s2_oob ? '0 : $signed(r_bx);
    assign vy = r_s2_oob ? '0 : $signed(r_by);
    assign vz = r_s2_oob ? '0 : $signed(r_bz);

    assign in_x    = (r_px >= r_lo_x) && (r_px <= r_hi_x);
    assign in_y    = (r_py >= r_lo_y) && (r_py <= r_hi_y);
    assign in_z    = (r_pz >= r_lo_z) && (r_pz <= r_hi_z);
    assign box_hit = in_x && in_y && (r_flat || in_z);

    always_comb begin
        n_state = r_state;
        n_issue = r_issue;
        n_icell = r_icell;
        n_ik    = r_ik;
        n_limit = r_limit;
        n_flat  = r_flat;
        n_s1_v  = 1'b0;
        n_s2_v  = 1'b0;
        n_box_v = 1'b0;
        n_out_v = r_out_v && !pop;
        n_out   = r_out;
        n_pend  = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_take && (i_q_cmd.op == OP_LOCATE)) begin
                    n_flat  = i_cfg.dims == DIMS_2D;
                    n_limit = clamp_count;
                    n_icell = '0;
                    n_ik    = '0;
                    n_pend  = '0;
                    if (clamp_count == '0) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_issue = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_s1_v  = r_issue;
                n_s2_v  = r_s1_v;
                n_box_v = r_s2_v && r_s2_tag.last;
                if (r_issue) begin
                    if (r_ik == last_k) begin
                        n_ik = '0;
                        if (r_icell == r_limit - 1'b1) begin
                            n_issue = 1'b0;
                        end else begin
                            n_icell = r_icell + 1'b1;
                        end
                    end else begin
                        n_ik = r_ik + 1'b1;
                    end
                end
                // first hit or last box ends the scan and flushes the pipe
                if (r_box_v && (box_hit || (r_box_cell == r_limit - 1'b1))) begin
                    n_pend.found   = box_hit;
                    n_pend.cell_id = box_hit ? r_box_cell[CELL_IDX_W-1:0] : '0;
                    n_issue = 1'b0;
                    n_s1_v  = 1'b0;
                    n_s2_v  = 1'b0;
                    n_box_v = 1'b0;
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_v || pop) begin
                    n_out_v = 1'b1;
                    n_out   = r_pend;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issue <= 1'b0;
            r_icell <= '0;
            r_ik    <= '0;
            r_limit <= '0;
            r_flat  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_box_v <= 1'b0;
            r_out_v <= 1'b0;
            r_out   <= '0;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_icell <= n_icell;
            r_ik    <= n_ik;
            r_limit <= n_limit;
            r_flat  <= n_flat;
            r_s1_v  <= n_s1_v;
            r_s2_v  <= n_s2_v;
            r_box_v <= n_box_v;
            r_out_v <= n_out_v;
            r_out   <= n_out;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag <= issue_tag;
        r_s2_tag <= r_s1_tag;
        r_s2_oob <= {{(32-VERTEX_W){1'b0}}, r_cdata} >= 32'(MAX_VERTICES);
        if (cmd_take && (i_q_cmd.op == OP_LOCATE)) begin
            r_px <= $signed(i_q_cmd.item.pos_x[CW-1:0]);
            r_py <= $signed(i_q_cmd.item.pos_y[CW-1:0]);
            r_pz <= $signed(i_q_cmd.item.pos_z[CW-1:0]);
        end
        if (r_s2_v) begin
            if (r_s2_tag.first) begin
                r_lo_x <= vx;
                r_hi_x <= vx;
                r_lo_y <= vy;
                r_hi_y <= vy;
                r_lo_z <= vz;
                r_hi_z <= vz;
            end else begin
                r_lo_x <= (vx < r_lo_x) ? vx : r_lo_x;
                r_hi_x <= (vx > r_hi_x) ? vx : r_hi_x;
                r_lo_y <= (vy < r_lo_y) ? vy : r_lo_y;
                r_hi_y <= (vy > r_hi_y) ? vy : r_hi_y;
                r_lo_z <= (vz < r_lo_z) ? vz : r_lo_z;
                r_hi_z <= (vz > r_hi_z) ? vz : r_hi_z;
            end
            r_box_cell <= r_s2_tag.cell_no;
        end
    end

    assign empty    = !r_out_v;
    assign o_result = r_out;

endmodule

FILE: design/mesh_point_cell_locator.sv
// Mesh point cell locator. Load items write one corner-table entry or one
// vertex coordinate and leave the scan engine idle; a locate item
// scans cells 0 .. min(cell_count, MAX_CELLS)-1 through a pipeline that reads
// one corner-table entry per cycle, so a locate reads the corners of cells 0
// up to the hit cell (4 corners in 2D, 8 in 3D), or of every cell in that
// range when no cell holds the point; the single corner-table read port
// sets that pace. Items wait in a four-entry queue while a locate runs, and
// one result register holds a finished result until it is popped. Tables are
// not cleared: every entry a locate reads must have been loaded first.
// Configuration is taken at any time, always ready.
module mesh_point_cell_locator import mpcl_pkg::*; #(
    parameter int MAX_CELLS    = MAX_CELLS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_in_item              i_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_push;
    t_cmd q_cmd_in;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims       <= DIMS_RESET;
            r_cfg.cell_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIMS:       r_cfg.dims       <= i_cfg_data[DIMS_W-1:0];
                CFG_CELL_COUNT: r_cfg.cell_count <= i_cfg_data[CELL_COUNT_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    mpcl_front #(
        .MAX_CELLS    (MAX_CELLS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd_in)
    );

    mpcl_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd_out)
    );

    mpcl_back #(
        .MAX_CELLS    (MAX_CELLS),
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd_out),
        .o_q_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .o_result  (o_result)
    );

endmodule
